// File: design/bcla_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcla_pkg
// Fixed field widths and stream packing shared by the bridge augment block.
// ----------------------------------------------------------------------------
package bcla_pkg;

  localparam int END_W       = 11;  // node number on the input stream
  localparam int CNT_W       = 11;  // node count register
  localparam int RES_W       = 10;  // added edge count
  localparam int IN_TDATA_W  = 24;  // two endpoints, padded to bytes
  localparam int OUT_TDATA_W = 16;  // one result, padded to bytes

endpackage
`default_nettype wire

// File: design/bcla_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcla_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bcla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// File: design/bridge_component_leaf_augment.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bridge_component_leaf_augment
// Counts the edges to add to a loaded graph so that no edge is a bridge.
// ----------------------------------------------------------------------------
// Input words carry one undirected edge each (end_a, end_b); tlast marks the
// final edge of a graph. Each edge is stored in both directions in linked
// adjacency lists held in RAM, skipping an entry already present. For each
// direction the block reads the list head, scans the list entry by entry and
// then inserts the entry unless it found it or the entry store is full.
// After the last edge, the block clears its walk stores, runs a depth-first
// walk with a RAM stack, a degree pass over the stored entries, counting each
// whose two labels differ, and a leaf count over the nodes.
// One output word then carries added_edges.
// The output sits in a register; if the receiver stalls, the block still
// takes the following graph and holds its next result until the first is
// taken. After each result, and after reset, the list heads are swept empty,
// and no input word is taken during the sweep. node_count is written through
// cfg_we_i and keeps its value across graphs; reset sets 1.
// ----------------------------------------------------------------------------
module bridge_component_leaf_augment #(
  parameter int MAX_NODES = 1024,
  parameter int MAX_EDGES = 2048
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [bcla_pkg::CNT_W-1:0]         cfg_wdata_i,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // [10:0] end_a, [21:11] end_b
  input  wire logic [bcla_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  input  wire logic                               s_axis_tlast,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // [9:0] added_edges
  output logic      [bcla_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
  import bcla_pkg::*;

  localparam int SLOTS = 2 * MAX_EDGES;
  localparam int NW    = $clog2(MAX_NODES + 1);
  localparam int CW    = $clog2(MAX_NODES + 2);
  localparam int EW    = $clog2(SLOTS);
  localparam int TW    = $clog2(SLOTS + 1);
  localparam int DW    = $clog2(SLOTS + 1);
  localparam int SW    = $clog2(MAX_NODES);

  typedef struct packed {
    logic          v;
    logic [EW-1:0] idx;
  } ptr_t;

  typedef struct packed {
    logic [NW-1:0] tgt;
    ptr_t          link;
  } edge_t;

  typedef struct packed {
    logic          vis;
    logic [NW-1:0] low;
    logic [NW-1:0] par;
  } node_t;

  typedef struct packed {
    logic [NW-1:0] node;
    ptr_t          cur;
  } frame_t;

  typedef enum logic [4:0] {
    S_HCLR, S_IDLE, S_LHEAD, S_LSCAN0, S_LSCAN, S_LINS, S_NCLR,
    S_RROOT, S_RROOTW, S_WTOP, S_WTGT, S_WVIS, S_WPOP1, S_WPOP2,
    S_ENODE, S_EHEAD, S_EEDGE, S_ETGT, S_ELB, S_ED1, S_ED2,
    S_KRD, S_KCHK, S_RES
  } state_e;

  state_e state_q, state_d;
  logic [CNT_W-1:0] node_count_q, node_count_d;
  logic [NW-1:0] a_q, a_d, b_q, b_d;
  logic last_q, last_d, dir_q, dir_d;
  ptr_t hold_q, hold_d;
  logic [TW-1:0] total_q, total_d;
  logic [CW-1:0] i_q, i_d;
  logic [NW-1:0] time_q, time_d;
  logic [NW-1:0] f_node_q, f_node_d, f_low_q, f_low_d, f_par_q, f_par_d;
  ptr_t f_cur_q, f_cur_d, lnk_q, lnk_d;
  logic [NW-1:0] sp_q, sp_d;
  logic [NW-1:0] v_q, v_d, c_low_q, c_low_d, c_node_q, c_node_d;
  logic [NW-1:0] la_q, la_d, lb_q, lb_d;
  logic [NW-1:0] leaf_q, leaf_d;
  logic out_valid_q, out_valid_d;
  logic [RES_W-1:0] out_data_q, out_data_d;

  // RAM ports
  logic head_we;  logic [NW-1:0] head_wa, head_ra;  ptr_t  head_wd, head_rd;
  logic edge_we;  logic [EW-1:0] edge_wa, edge_ra;  edge_t edge_wd, edge_rd;
  logic node_we;  logic [NW-1:0] node_wa, node_ra;  node_t node_wd, node_rd;
  logic deg_we;   logic [NW-1:0] deg_wa, deg_ra;
  logic [DW-1:0] deg_wd, deg_rd;
  logic stk_we;   logic [SW-1:0] stk_wa, stk_ra;    frame_t stk_wd, stk_rd;

  bcla_ram #(.WIDTH(EW + 1), .DEPTH(MAX_NODES + 1)) u_head (
    .clk_i, .we_i(head_we), .waddr_i(head_wa), .wdata_i(head_wd),
    .raddr_i(head_ra), .rdata_o(head_rd));
  bcla_ram #(.WIDTH(NW + EW + 1), .DEPTH(SLOTS)) u_edge (
    .clk_i, .we_i(edge_we), .waddr_i(edge_wa), .wdata_i(edge_wd),
    .raddr_i(edge_ra), .rdata_o(edge_rd));
  bcla_ram #(.WIDTH(1 + 2 * NW), .DEPTH(MAX_NODES + 1)) u_node (
    .clk_i, .we_i(node_we), .waddr_i(node_wa), .wdata_i(node_wd),
    .raddr_i(node_ra), .rdata_o(node_rd));
  bcla_ram #(.WIDTH(DW), .DEPTH(MAX_NODES + 1)) u_deg (
    .clk_i, .we_i(deg_we), .waddr_i(deg_wa), .wdata_i(deg_wd),
    .raddr_i(deg_ra), .rdata_o(deg_rd));
  bcla_ram #(.WIDTH(NW + EW + 1), .DEPTH(MAX_NODES)) u_stk (
    .clk_i, .we_i(stk_we), .waddr_i(stk_wa), .wdata_i(stk_wd),
    .raddr_i(stk_ra), .rdata_o(stk_rd));

  logic [END_W-1:0] in_a, in_b;
  logic in_ok;
  logic [CW-1:0] n_lim;
  logic [NW-1:0] from_n, to_n;
  logic [NW-1:0] i_n;
  logic [NW:0] leaf_inc;

  assign in_a  = s_axis_tdata[END_W-1:0];
  assign in_b  = s_axis_tdata[2*END_W-1:END_W];
  assign in_ok = (in_a != '0) && (32'(in_a) <= 32'(MAX_NODES)) &&
                 (in_b != '0) && (32'(in_b) <= 32'(MAX_NODES));
  assign n_lim = (32'(node_count_q) > 32'(MAX_NODES)) ? CW'(MAX_NODES)
                                                     : CW'(node_count_q);
  assign from_n = dir_q ? b_q : a_q;
  assign to_n   = dir_q ? a_q : b_q;
  assign i_n    = i_q[NW-1:0];
  assign leaf_inc = (NW + 1)'(leaf_q) + (NW + 1)'(1);

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'(out_data_q);

  always_comb begin
    state_d      = state_q;
    node_count_d = cfg_we_i ? cfg_wdata_i : node_count_q;
    a_d = a_q;  b_d = b_q;  last_d = last_q;  dir_d = dir_q;
    hold_d = hold_q;  total_d = total_q;  i_d = i_q;  time_d = time_q;
    f_node_d = f_node_q;  f_low_d = f_low_q;  f_par_d = f_par_q;
    f_cur_d = f_cur_q;  lnk_d = lnk_q;  sp_d = sp_q;  v_d = v_q;
    c_low_d = c_low_q;  c_node_d = c_node_q;  la_d = la_q;  lb_d = lb_q;
    leaf_d = leaf_q;
    out_valid_d = out_valid_q & ~m_axis_tready;
    out_data_d  = out_data_q;

    head_we = 1'b0;  head_wa = from_n;  head_wd = '0;  head_ra = from_n;
    edge_we = 1'b0;  edge_wa = total_q[EW-1:0];  edge_wd = '0;  edge_ra = '0;
    node_we = 1'b0;  node_wa = i_n;  node_wd = '0;  node_ra = i_n;
    deg_we  = 1'b0;  deg_wa = i_n;  deg_wd = '0;  deg_ra = i_n;
    stk_we  = 1'b0;  stk_wa = SW'(sp_q - NW'(1));  stk_wd = '0;
    stk_ra  = SW'(sp_q - NW'(2));

    case (state_q)
      S_HCLR: begin
        head_we = 1'b1;
        head_wa = i_n;
        total_d = '0;
        i_d     = i_q + CW'(1);
        if (32'(i_q) == 32'(MAX_NODES)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_axis_tvalid) begin
          a_d    = NW'(in_a);
          b_d    = NW'(in_b);
          last_d = s_axis_tlast;
          dir_d  = 1'b0;
          if (in_ok) begin
            state_d = S_LHEAD;
          end else if (s_axis_tlast) begin
            i_d     = '0;
            state_d = S_NCLR;
          end
        end
      end
      S_LHEAD: begin
        state_d = S_LSCAN0;
      end
      S_LSCAN0: begin
        hold_d  = head_rd;
        edge_ra = head_rd.idx;
        state_d = head_rd.v ? S_LSCAN : S_LINS;
      end
      S_LSCAN: begin
        edge_ra = edge_rd.link.idx;
        if (edge_rd.tgt == to_n) begin
          dir_d = 1'b1;
          if (!dir_q) begin
            state_d = S_LHEAD;
          end else if (last_q) begin
            i_d     = '0;
            state_d = S_NCLR;
          end else begin
            state_d = S_IDLE;
          end
        end else if (!edge_rd.link.v) begin
          state_d = S_LINS;
        end
      end
      S_LINS: begin
        if (total_q < TW'(SLOTS)) begin
          edge_we = 1'b1;
          edge_wd = '{tgt: to_n, link: hold_q};
          head_we = 1'b1;
          head_wd = '{v: 1'b1, idx: total_q[EW-1:0]};
          total_d = total_q + TW'(1);
        end
        dir_d = 1'b1;
        if (!dir_q) begin
          state_d = S_LHEAD;
        end else if (last_q) begin
          i_d     = '0;
          state_d = S_NCLR;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_NCLR: begin
        node_we = 1'b1;
        deg_we  = 1'b1;
        i_d     = i_q + CW'(1);
        if (32'(i_q) == 32'(MAX_NODES)) begin
          i_d     = CW'(1);
          time_d  = '0;
          leaf_d  = '0;
          state_d = S_RROOT;
        end
      end
      S_RROOT: begin
        head_ra = i_n;
        if (i_q > n_lim) begin
          i_d     = CW'(1);
          state_d = S_ENODE;
        end else begin
          state_d = S_RROOTW;
        end
      end
      S_RROOTW: begin
        if (node_rd.vis) begin
          i_d     = i_q + CW'(1);
          state_d = S_RROOT;
        end else begin
          node_we  = 1'b1;
          node_wd  = '{vis: 1'b1, low: time_q + NW'(1), par: '0};
          time_d   = time_q + NW'(1);
          f_node_d = i_n;
          f_cur_d  = head_rd;
          f_low_d  = time_q + NW'(1);
          f_par_d  = '0;
          sp_d     = NW'(1);
          state_d  = S_WTOP;
        end
      end
      S_WTOP: begin
        edge_ra = f_cur_q.idx;
        if (f_cur_q.v) begin
          state_d = S_WTGT;
        end else if (sp_q == NW'(1)) begin
          i_d     = i_q + CW'(1);
          state_d = S_RROOT;
        end else begin
          state_d = S_WPOP1;
        end
      end
      S_WTGT: begin
        v_d     = edge_rd.tgt;
        lnk_d   = edge_rd.link;
        node_ra = edge_rd.tgt;
        head_ra = edge_rd.tgt;
        state_d = S_WVIS;
      end
      S_WVIS: begin
        if (!node_rd.vis) begin
          // Descend: the current frame goes to the stack with its cursor
          // still on this entry, so the pop can fold the child's label in.
          stk_we   = 1'b1;
          stk_wd   = '{node: f_node_q, cur: f_cur_q};
          node_we  = 1'b1;
          node_wa  = v_q;
          node_wd  = '{vis: 1'b1, low: time_q + NW'(1), par: f_node_q};
          time_d   = time_q + NW'(1);
          f_par_d  = f_node_q;
          f_node_d = v_q;
          f_low_d  = time_q + NW'(1);
          f_cur_d  = head_rd;
          sp_d     = sp_q + NW'(1);
        end else begin
          if ((f_low_q > node_rd.low) && (f_par_q != v_q)) begin
            f_low_d = node_rd.low;
            node_we = 1'b1;
            node_wa = f_node_q;
            node_wd = '{vis: 1'b1, low: node_rd.low, par: f_par_q};
          end
          f_cur_d = lnk_q;
        end
        state_d = S_WTOP;
      end
      S_WPOP1: begin
        node_ra  = stk_rd.node;
        edge_ra  = stk_rd.cur.idx;
        c_low_d  = f_low_q;
        c_node_d = f_node_q;
        f_node_d = stk_rd.node;
        sp_d     = sp_q - NW'(1);
        state_d  = S_WPOP2;
      end
      S_WPOP2: begin
        f_par_d = node_rd.par;
        if ((node_rd.low > c_low_q) && (node_rd.par != c_node_q)) begin
          f_low_d = c_low_q;
          node_we = 1'b1;
          node_wa = f_node_q;
          node_wd = '{vis: 1'b1, low: c_low_q, par: node_rd.par};
        end else begin
          f_low_d = node_rd.low;
        end
        f_cur_d = edge_rd.link;
        state_d = S_WTOP;
      end
      S_ENODE: begin
        head_ra = i_n;
        if (i_q > n_lim) begin
          i_d     = CW'(1);
          state_d = S_KRD;
        end else begin
          state_d = S_EHEAD;
        end
      end
      S_EHEAD: begin
        la_d    = node_rd.low;
        f_cur_d = head_rd;
        state_d = S_EEDGE;
      end
      S_EEDGE: begin
        edge_ra = f_cur_q.idx;
        if (f_cur_q.v) begin
          state_d = S_ETGT;
        end else begin
          i_d     = i_q + CW'(1);
          state_d = S_ENODE;
        end
      end
      S_ETGT: begin
        node_ra = edge_rd.tgt;
        lnk_d   = edge_rd.link;
        state_d = S_ELB;
      end
      S_ELB: begin
        lb_d   = node_rd.low;
        deg_ra = la_q;
        if (la_q != node_rd.low) begin
          state_d = S_ED1;
        end else begin
          f_cur_d = lnk_q;
          state_d = S_EEDGE;
        end
      end
      S_ED1: begin
        deg_we  = 1'b1;
        deg_wa  = la_q;
        deg_wd  = deg_rd + DW'(1);
        deg_ra  = lb_q;
        state_d = S_ED2;
      end
      S_ED2: begin
        deg_we  = 1'b1;
        deg_wa  = lb_q;
        deg_wd  = deg_rd + DW'(1);
        f_cur_d = lnk_q;
        state_d = S_EEDGE;
      end
      S_KRD: begin
        state_d = (i_q > n_lim) ? S_RES : S_KCHK;
      end
      S_KCHK: begin
        if (deg_rd == DW'(2)) begin
          leaf_d = leaf_q + NW'(1);
        end
        i_d     = i_q + CW'(1);
        state_d = S_KRD;
      end
      S_RES: begin
        if (!out_valid_q) begin
          out_valid_d = 1'b1;
          out_data_d  = RES_W'(leaf_inc >> 1);
          i_d         = '0;
          state_d     = S_HCLR;
        end
      end
      default: begin
        state_d = S_HCLR;
        i_d     = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_HCLR;
      node_count_q <= CNT_W'(1);
      i_q          <= '0;
      total_q      <= '0;
      out_valid_q  <= 1'b0;
      sp_q         <= '0;
      time_q       <= '0;
      leaf_q       <= '0;
    end else begin
      state_q      <= state_d;
      node_count_q <= node_count_d;
      i_q          <= i_d;
      total_q      <= total_d;
      out_valid_q  <= out_valid_d;
      sp_q         <= sp_d;
      time_q       <= time_d;
      leaf_q       <= leaf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;  b_q <= b_d;  last_q <= last_d;  dir_q <= dir_d;
    hold_q <= hold_d;  f_node_q <= f_node_d;  f_low_q <= f_low_d;
    f_par_q <= f_par_d;  f_cur_q <= f_cur_d;  lnk_q <= lnk_d;  v_q <= v_d;
    c_low_q <= c_low_d;  c_node_q <= c_node_d;  la_q <= la_d;  lb_q <= lb_d;
    out_data_q <= out_data_d;
  end

endmodule
`default_nettype wire

// File: tb/tb_bridge_component_leaf_augment.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bridge_component_leaf_augment
// Self-checking bench for the bridge augment block: directed rows, then random
// graphs under several idle and stall mixes; each added_edges word is compared
// with the row's typed value or an in-bench depth-first bridge predictor.
// ----------------------------------------------------------------------------
module tb_bridge_component_leaf_augment;
  import bcla_pkg::*;

  localparam int NODES_MAX  = 1024;
  localparam int SLOT_COUNT = 4096;
  localparam int NO_ENTRY   = -1;
  localparam int DRAIN_WAIT = 2400;
  localparam int CYCLE_CAP  = 3000000;

  // Row kinds of the directed table.
  localparam int OP_EDGE  = 0;
  localparam int OP_NODES = 1;
  localparam int NO_TYPED = -1;
  localparam int DIR_ROWS = 25;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CNT_W-1:0]       cfg_wdata_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tlast = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  bridge_component_leaf_augment uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always #10 clk_i = ~clk_i;

  // Directed rows: kind, end_a or node count, end_b, last, typed result.
  // A single self loop after reset leaves no bridge at all. Out-of-range
  // endpoints are dropped and duplicates are not stored twice. Node 10 is
  // reached through the walk but lies above the node count.
  int dir_tab [DIR_ROWS][5] = '{
    '{OP_EDGE,  1,    1,    1, 0},
    '{OP_NODES, 0,    0,    0, NO_TYPED},
    '{OP_EDGE,  1,    2,    1, 0},
    '{OP_NODES, 4,    0,    0, NO_TYPED},
    '{OP_EDGE,  1,    2,    0, NO_TYPED},
    '{OP_EDGE,  2,    3,    0, NO_TYPED},
    '{OP_EDGE,  3,    4,    1, 1},
    '{OP_EDGE,  0,    3,    0, NO_TYPED},
    '{OP_EDGE,  2047, 1,    0, NO_TYPED},
    '{OP_EDGE,  1025, 2,    0, NO_TYPED},
    '{OP_EDGE,  1,    2,    0, NO_TYPED},
    '{OP_EDGE,  2,    1,    0, NO_TYPED},
    '{OP_EDGE,  1,    2,    1, 1},
    '{OP_EDGE,  0,    0,    1, 0},
    '{OP_NODES, 3,    0,    0, NO_TYPED},
    '{OP_EDGE,  1,    2,    0, NO_TYPED},
    '{OP_EDGE,  2,    3,    0, NO_TYPED},
    '{OP_EDGE,  3,    10,   1, NO_TYPED},
    '{OP_NODES, 2047, 0,    0, NO_TYPED},
    '{OP_EDGE,  1024, 1,    0, NO_TYPED},
    '{OP_EDGE,  1024, 1024, 0, NO_TYPED},
    '{OP_EDGE,  1,    2,    1, NO_TYPED},
    '{OP_NODES, 1024, 0,    0, NO_TYPED},
    '{OP_EDGE,  1024, 1023, 0, NO_TYPED},
    '{OP_EDGE,  1,    1024, 1, NO_TYPED}
  };

  // Predictor state: adjacency lists plus the walk stores.
  int node_cnt;
  int list_first [0:NODES_MAX];
  int entry_to   [0:SLOT_COUNT-1];
  int entry_next [0:SLOT_COUNT-1];
  int entries_used;
  bit seen       [0:NODES_MAX];
  int low_of     [0:NODES_MAX];
  int parent_of  [0:NODES_MAX];
  int degree_of  [0:NODES_MAX];
  int frame_node [0:NODES_MAX];
  int frame_cur  [0:NODES_MAX];
  int clock_tick;

  logic [RES_W-1:0] added_due [$];
  int errors = 0;
  int send_idle = 0;
  int recv_stall = 0;
  int edges_sent = 0;

  function automatic void clear_lists();
    for (int i = 0; i <= NODES_MAX; i++) list_first[i] = NO_ENTRY;
    entries_used = 0;
  endfunction

  function automatic void store_direction(int from, int to);
    int e;
    e = list_first[from];
    while (e != NO_ENTRY) begin
      if (entry_to[e] == to) return;
      e = entry_next[e];
    end
    if (entries_used >= SLOT_COUNT) return;
    entry_to[entries_used] = to;
    entry_next[entries_used] = list_first[from];
    list_first[from] = entries_used;
    entries_used++;
  endfunction

  function automatic void take_low(int now, int v);
    if (low_of[now] > low_of[v] && parent_of[now] != v) low_of[now] = low_of[v];
  endfunction

  function automatic void visit(int v);
    clock_tick++;
    low_of[v] = clock_tick;
    seen[v] = 1'b1;
  endfunction

  function automatic void walk_tree(int root);
    int sp;
    int v;
    parent_of[root] = 0;
    visit(root);
    frame_node[0] = root;
    frame_cur[0] = list_first[root];
    sp = 1;
    while (sp > 0) begin
      if (frame_cur[sp-1] == NO_ENTRY) begin
        sp--;
        if (sp > 0) begin
          take_low(frame_node[sp-1], entry_to[frame_cur[sp-1]]);
          frame_cur[sp-1] = entry_next[frame_cur[sp-1]];
        end
      end else begin
        v = entry_to[frame_cur[sp-1]];
        if (!seen[v] && sp <= NODES_MAX) begin
          parent_of[v] = frame_node[sp-1];
          visit(v);
          frame_node[sp] = v;
          frame_cur[sp] = list_first[v];
          sp++;
        end else begin
          take_low(frame_node[sp-1], v);
          frame_cur[sp-1] = entry_next[frame_cur[sp-1]];
        end
      end
    end
  endfunction

  function automatic logic [RES_W-1:0] count_added();
    int n;
    int e;
    int la;
    int lb;
    int leaves;
    n = (node_cnt > NODES_MAX) ? NODES_MAX : node_cnt;
    for (int i = 0; i <= NODES_MAX; i++) begin
      seen[i] = 1'b0;
      low_of[i] = 0;
      degree_of[i] = 0;
    end
    clock_tick = 0;
    leaves = 0;
    for (int i = 1; i <= n; i++) if (!seen[i]) walk_tree(i);
    for (int i = 1; i <= n; i++) begin
      e = list_first[i];
      while (e != NO_ENTRY) begin
        la = low_of[i];
        lb = low_of[entry_to[e]];
        if (la != lb && la <= NODES_MAX && lb <= NODES_MAX) begin
          degree_of[la]++;
          degree_of[lb]++;
        end
        e = entry_next[e];
      end
    end
    for (int i = 1; i <= n; i++) if (degree_of[i] == 2) leaves++;
    return RES_W'((leaves + 1) / 2);
  endfunction

  // Drives one edge word; a non-negative typed value overrides the predictor.
  task automatic send_edge(int a, int b, bit last, int typed = -1);
    logic [RES_W-1:0] got;
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {2'b00, END_W'(b), END_W'(a)};
    s_axis_tlast <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    edges_sent++;
    if (a >= 1 && a <= NODES_MAX && b >= 1 && b <= NODES_MAX) begin
      store_direction(a, b);
      store_direction(b, a);
    end
    if (last) begin
      got = count_added();
      added_due.push_back(typed >= 0 ? RES_W'(typed) : got);
      clear_lists();
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (added_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  // Register writes only happen with the block idle.
  task automatic set_nodes(int n);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= CNT_W'(n);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    node_cnt = n & 32'h7FF;
  endtask

  task automatic random_graph(int n);
    int k;
    int a;
    int b;
    k = $urandom_range(12, 1);
    for (int j = 0; j < k; j++) begin
      if ($urandom_range(99) < 85) begin
        a = $urandom_range(n + 2, 1);
        b = ($urandom_range(9) == 0) ? a : $urandom_range(n + 2, 1);
      end else begin
        a = $urandom_range(2047);
        b = $urandom_range(2047);
      end
      send_edge(a, b, j == k - 1);
    end
  endtask

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (added_due.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %0d", $time,
                 m_axis_tdata[RES_W-1:0]);
        errors++;
      end else begin
        if (m_axis_tdata[RES_W-1:0] !== added_due[0]) begin
          $display("%0t: added_edges mismatch, expected %0d, actual %0d", $time,
                   added_due[0], m_axis_tdata[RES_W-1:0]);
          errors++;
        end
        void'(added_due.pop_front());
      end
    end
  end

  int cycles = 0;
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int n;
    node_cnt = 1;
    clear_lists();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < DIR_ROWS; r++) begin
      if (dir_tab[r][0] == OP_NODES) begin
        set_nodes(dir_tab[r][1]);
      end else begin
        send_edge(dir_tab[r][1], dir_tab[r][2], dir_tab[r][3] != 0, dir_tab[r][4]);
      end
    end

    for (int phase = 0; phase < 4; phase++) begin
      n = (phase == 1) ? 1 : $urandom_range(30, 2);
      set_nodes(n);
      case (phase)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 47; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 47; end
        default: begin send_idle = 36; recv_stall = 36; end
      endcase
      while (edges_sent < 250 * (phase + 1)) begin
        if (phase == 1 && edges_sent > 350) n = 1024;
        random_graph(n);
      end
    end

    drain();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/bcla_pkg.sv
design/bcla_ram.sv
design/bridge_component_leaf_augment.sv
tb/tb_bridge_component_leaf_augment.sv
